// ----- sv/sle_pkg.sv -----
// shared types and constants of the serial line editor
package sle_pkg;

    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NAK   = 8'h15;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef logic [2:0] t_cls;
    localparam t_cls CLS_NONE   = 3'd0;
    localparam t_cls CLS_PRINT  = 3'd1;
    localparam t_cls CLS_ERASE  = 3'd2;
    localparam t_cls CLS_CANCEL = 3'd3;
    localparam t_cls CLS_KILL   = 3'd4;
    localparam t_cls CLS_ENTER  = 3'd5;

    typedef logic [3:0] t_sel;
    localparam t_sel SEL_RX    = 4'd0;
    localparam t_sel SEL_BS    = 4'd1;
    localparam t_sel SEL_SP    = 4'd2;
    localparam t_sel SEL_CARET = 4'd3;
    localparam t_sel SEL_C     = 4'd4;
    localparam t_sel SEL_CR    = 4'd5;
    localparam t_sel SEL_LF    = 4'd6;
    localparam t_sel SEL_GT    = 4'd7;
    localparam t_sel SEL_LINE  = 4'd8;

    typedef struct packed {
        logic take;
        logic store;
        logic dec_fill;
        logic clr_fill;
        logic idx_clr;
        logic idx_inc;
        logic emit;
        t_sel sel;
        logic last;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic fill_zero;
        logic fill_one;
        logic fill_full;
        logic idx_last;
        logic out_free;
    } t_stat;

endpackage

// ----- sv/sle_ctrl.sv -----
// sequencing state machine of the serial line editor
module sle_ctrl
    import sle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ECHO   = 3'd1;
    localparam logic [2:0] ST_ERASE  = 3'd2;
    localparam logic [2:0] ST_CARET  = 3'd3;
    localparam logic [2:0] ST_CRLF   = 3'd4;
    localparam logic [2:0] ST_LINE   = 3'd5;
    localparam logic [2:0] ST_PROMPT = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_multi, n_multi;
    logic       w_emit;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_emit     = (r_state != ST_IDLE) && i_stat.out_free;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_multi = r_multi;
        o_cmd   = '0;
        o_cmd.sel  = SEL_RX;
        o_cmd.emit = w_emit;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_phase    = 2'd0;
                    case (i_stat.cls)
                        CLS_ENTER: n_state = ST_CRLF;
                        CLS_ERASE: begin
                            if (!i_stat.fill_zero) begin
                                n_state = ST_ERASE;
                                n_multi = 1'b0;
                            end
                        end
                        CLS_KILL: begin
                            if (!i_stat.fill_zero) begin
                                n_state = ST_ERASE;
                                n_multi = 1'b1;
                            end
                        end
                        CLS_CANCEL: begin
                            o_cmd.clr_fill = 1'b1;
                            n_state        = ST_CARET;
                        end
                        CLS_PRINT: begin
                            if (!i_stat.fill_full) begin
                                o_cmd.store = 1'b1;
                                n_state     = ST_ECHO;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ECHO: begin
                o_cmd.sel  = SEL_RX;
                o_cmd.last = 1'b1;
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ERASE: begin
                o_cmd.sel  = (r_phase == 2'd1) ? SEL_SP : SEL_BS;
                o_cmd.last = (r_phase == 2'd2) && (!r_multi || i_stat.fill_one);
                if (w_emit) begin
                    if (r_phase == 2'd2) begin
                        o_cmd.dec_fill = 1'b1;
                        n_phase        = 2'd0;
                        if (o_cmd.last) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            ST_CARET: begin
                o_cmd.sel = (r_phase == 2'd0) ? SEL_CARET : SEL_C;
                if (w_emit) begin
                    if (r_phase == 2'd0) begin
                        n_phase = 2'd1;
                    end else begin
                        n_phase = 2'd0;
                        n_state = ST_CRLF;
                    end
                end
            end
            ST_CRLF: begin
                o_cmd.sel = (r_phase == 2'd0) ? SEL_CR : SEL_LF;
                if (w_emit) begin
                    if (r_phase == 2'd0) begin
                        n_phase = 2'd1;
                    end else begin
                        n_phase       = 2'd0;
                        o_cmd.idx_clr = 1'b1;
                        n_state       = i_stat.fill_zero ? ST_PROMPT : ST_LINE;
                    end
                end
            end
            ST_LINE: begin
                o_cmd.sel = SEL_LINE;
                if (w_emit) begin
                    o_cmd.idx_inc = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = ST_PROMPT;
                    end
                end
            end
            ST_PROMPT: begin
                o_cmd.sel  = (r_phase == 2'd0) ? SEL_GT : SEL_SP;
                o_cmd.last = (r_phase == 2'd1);
                if (w_emit) begin
                    if (r_phase == 2'd0) begin
                        n_phase = 2'd1;
                    end else begin
                        n_phase        = 2'd0;
                        o_cmd.clr_fill = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= 2'd0;
            r_multi <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_multi <= n_multi;
        end
    end

endmodule

// ----- sv/sle_dp.sv -----
// line store, fill count, byte decode and output register
module sle_dp
    import sle_pkg::*;
#(
    parameter int BUFFER_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_ready,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_dest,
    output logic       o_line_end,
    output logic       o_last
);

    localparam int LINE_CAP = BUFFER_BYTES - 1;
    localparam int FILL_W   = $clog2(BUFFER_BYTES);
    localparam int IDX_W    = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
    localparam logic [FILL_W-1:0] FILL_CAP = FILL_W'(LINE_CAP);
    localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

    logic [6:0]        r_store [LINE_CAP];
    logic [FILL_W-1:0] r_fill;
    logic [IDX_W-1:0]  r_idx;
    logic [7:0]        r_rx;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_dest;
    logic              r_line_end;
    logic              r_last;
    logic [7:0]        w_byte;
    logic [7:0]        w_line_char;
    t_cls              w_cls;

    always_comb begin
        unique case (i_rx_byte) inside
            CH_CR, CH_LF:     w_cls = CLS_ENTER;
            CH_DEL, CH_BS:    w_cls = CLS_ERASE;
            CH_ETX:           w_cls = CLS_CANCEL;
            CH_NAK:           w_cls = CLS_KILL;
            [CH_SP:CH_TILDE]: w_cls = CLS_PRINT;
            default:          w_cls = CLS_NONE;
        endcase
    end

    assign w_line_char = {1'b0, r_store[r_idx]};

    always_comb begin
        case (i_cmd.sel)
            SEL_RX:    w_byte = r_rx;
            SEL_BS:    w_byte = CH_BS;
            SEL_SP:    w_byte = CH_SP;
            SEL_CARET: w_byte = CH_CARET;
            SEL_C:     w_byte = CH_C;
            SEL_CR:    w_byte = CH_CR;
            SEL_LF:    w_byte = CH_LF;
            SEL_GT:    w_byte = CH_GT;
            SEL_LINE:  w_byte = w_line_char;
            default:   w_byte = CH_SP;
        endcase
    end

    assign o_stat.cls       = w_cls;
    assign o_stat.fill_zero = (r_fill == '0);
    assign o_stat.fill_one  = (r_fill == FILL_ONE);
    assign o_stat.fill_full = (r_fill == FILL_CAP);
    assign o_stat.idx_last  = ((FILL_W'(r_idx) + FILL_ONE) == r_fill);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_fill <= r_fill + FILL_ONE;
            end else if (i_cmd.clr_fill) begin
                r_fill <= '0;
            end else if (i_cmd.dec_fill) begin
                r_fill <= r_fill - FILL_ONE;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_rx <= i_rx_byte;
        end
        if (i_cmd.store) begin
            r_store[r_fill[IDX_W-1:0]] <= i_rx_byte[6:0];
        end
        if (i_cmd.emit) begin
            r_out_byte <= w_byte;
            r_dest     <= (i_cmd.sel == SEL_LINE);
            r_line_end <= (i_cmd.sel == SEL_LINE) && o_stat.idx_last;
            r_last     <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_dest      = r_dest;
    assign o_line_end  = r_line_end;
    assign o_last      = r_last;

endmodule

// ----- sv/serial_line_editor.sv -----
// top level of the serial line editor
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_rx_byte
//  out     | output    | o_out_valid / i_out_ready | o_out_byte o_dest o_line_end o_last
//
// a byte that causes results is taken in a transfer, then each result passes
// through the single output register; a byte with no result is only taken,
// ctrl+u on a full line emits backspace, space, backspace for each stored byte
// reset empties the line and the output register, no clearing pass
// a stalled output holds the sequencer; the next byte is taken while the last
// result of the previous one still waits
module serial_line_editor
    import sle_pkg::*;
#(
    parameter int BUFFER_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_dest,
    output logic       o_line_end,
    output logic       o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sle_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (i_rx_byte),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_dest      (o_dest),
        .o_line_end  (o_line_end),
        .o_last      (o_last)
    );

endmodule
